// ----- design/srrg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the speed ramp reload generator.
// No dependencies; every other design file imports this package.
package srrg_pkg;

  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned RELOAD_W = 32;
  localparam int unsigned DIVF_W   = 48;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CNT_W    = $clog2(DIVF_W);

  localparam logic [CFG_IDX_W-1:0] CFG_DIVISION_FACTOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE       = 1'd1;

  localparam logic [SPEED_W-1:0] STEP_SIZE_RESET = 16'd80;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SEL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_PUT  = 4'b1000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture a new target and set up the ramp
    logic sel;       // pick the next ramp speed and arm the divider
    logic div_step;  // one restoring-division step
    logic put;       // load the output register and advance
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;  // the current step is the final quotient bit
    logic out_free;  // output register can take a new item
    logic last_sel;  // selected speed is the final one of the ramp
  } status_t;

endpackage

// ----- design/srrg_if.sv -----
`timescale 1ns / 1ps
// Handshake channel interfaces: target input, result output, configuration writes.
// Depends on srrg_pkg for field widths.
interface srrg_in_if import srrg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] target_speed;
  modport source (output valid, output target_speed, input ready);
  modport sink   (input valid, input target_speed, output ready);
endinterface

interface srrg_out_if import srrg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RELOAD_W-1:0] reload_value;
  logic [SPEED_W-1:0]  ramp_speed;
  logic                last;
  modport source (output valid, output reload_value, output ramp_speed, output last,
                  input ready);
  modport sink   (input valid, input reload_value, input ramp_speed, input last,
                  output ready);
endinterface

interface srrg_cfg_if import srrg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIVF_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/srrg_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the ramp generator: select speed, divide, hand over the result.
// Depends on srrg_pkg.
module srrg_ctrl import srrg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SEL;
        end
      end
      ST_SEL: begin
        cmd_o.sel = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_PUT;
      end
      ST_PUT: begin
        // hold until the output register drains
        if (status_i.out_free) begin
          cmd_o.put = 1'b1;
          state_d   = status_i.last_sel ? ST_IDLE : ST_SEL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/srrg_dp.sv -----
`timescale 1ns / 1ps
// Datapath: configuration registers, ramp stepping, restoring divider, output register.
// Depends on srrg_pkg.
module srrg_dp import srrg_pkg::*; #(
  parameter int unsigned MAX_RAMP_STEPS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic [SPEED_W-1:0]   target_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIVF_W-1:0]    cfg_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [RELOAD_W-1:0]  out_reload_o,
  output logic [SPEED_W-1:0]   out_speed_o,
  output logic                 out_last_o
);

  localparam int unsigned K_W   = $clog2(MAX_RAMP_STEPS + 1);
  localparam int unsigned ACC_W = SPEED_W + K_W;
  localparam logic [K_W-1:0] K_MAX = K_W'(MAX_RAMP_STEPS);

  logic [DIVF_W-1:0]   divf_q;
  logic [SPEED_W-1:0]  step_q;
  logic [SPEED_W-1:0]  prev_q, target_q, diff_q, spd_q;
  logic                ramp_q, up_q, last_q;
  logic [K_W-1:0]      k_q;
  logic [ACC_W-1:0]    acc_q;
  logic [SPEED_W-1:0]  rem_q;
  logic [DIVF_W-1:0]   quo_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                out_valid_q, out_last_q;
  logic [RELOAD_W-1:0] out_reload_q;
  logic [SPEED_W-1:0]  out_speed_q;

  logic [SPEED_W-1:0]  step_eff;
  logic [SPEED_W:0]    prev_plus;
  logic                up, down, is_mid;
  logic [SPEED_W-1:0]  mid_spd;
  logic [SPEED_W:0]    rem_sh, rem_sub;
  logic                fits;
  logic [RELOAD_W-1:0] reload;

  always_comb begin
    step_eff  = (step_q == '0) ? SPEED_W'(1) : step_q;
    prev_plus = {1'b0, prev_q} + {1'b0, step_eff};
    up        = {1'b0, target_i} > prev_plus;
    down      = (prev_q > step_eff) && (target_i < (prev_q - step_eff));
    // another intermediate speed while k*step < |diff| and k below the cap
    is_mid    = ramp_q && (acc_q < {{K_W{1'b0}}, diff_q}) && (k_q < K_MAX);
    mid_spd   = up_q ? (prev_q + acc_q[SPEED_W-1:0]) : (prev_q - acc_q[SPEED_W-1:0]);
    rem_sh    = {rem_q, quo_q[DIVF_W-1]};
    rem_sub   = rem_sh - {1'b0, spd_q};
    fits      = (rem_sh >= {1'b0, spd_q});
    if (spd_q == '0) begin
      reload = '0;
    end else if (quo_q[DIVF_W-1:RELOAD_W] != '0) begin
      reload = '1;
    end else begin
      reload = quo_q[RELOAD_W-1:0];
    end
  end

  assign status_o.div_last = (cnt_q == CNT_W'(DIVF_W - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.last_sel = last_q;

  // Configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divf_q      <= '0;
      step_q      <= STEP_SIZE_RESET;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == CFG_DIVISION_FACTOR)) divf_q <= cfg_data_i;
      if (cfg_we_i && (cfg_index_i == CFG_STEP_SIZE))       step_q <= cfg_data_i[SPEED_W-1:0];
      if (cmd_i.put && last_q) prev_q <= target_q;
      if (cmd_i.put) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Ramp and divider payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      target_q <= target_i;
      ramp_q   <= up || down;
      up_q     <= up;
      diff_q   <= up ? (target_i - prev_q) : (prev_q - target_i);
      k_q      <= K_W'(1);
      acc_q    <= {{K_W{1'b0}}, step_eff};
    end
    if (cmd_i.sel) begin
      spd_q  <= is_mid ? mid_spd : target_q;
      last_q <= !is_mid;
      rem_q  <= '0;
      quo_q  <= divf_q;
      cnt_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= fits ? rem_sub[SPEED_W-1:0] : rem_sh[SPEED_W-1:0];
      quo_q <= {quo_q[DIVF_W-2:0], fits};
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.put) begin
      out_reload_q <= reload;
      out_speed_q  <= spd_q;
      out_last_q   <= last_q;
      if (!last_q) begin
        k_q   <= k_q + K_W'(1);
        acc_q <= acc_q + {{K_W{1'b0}}, step_eff};
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_reload_o = out_reload_q;
  assign out_speed_o  = out_speed_q;
  assign out_last_o   = out_last_q;

endmodule

// ----- design/speed_ramp_reload_generator_core.sv -----
`timescale 1ns / 1ps
// Top level of the speed ramp reload generator: controller plus datapath.
// Depends on srrg_pkg, srrg_if, srrg_ctrl and srrg_dp.
//
//   channel  direction  payload                               moves per item
//   in_i     sink       target_speed                           one
//   out_o    source     reload_value, ramp_speed, last         1 .. MAX_RAMP_STEPS
//   cfg_i    sink       index (0 division_factor, 1 step_size), data   any, while idle
//
// Sequence: each result takes a speed pick, a bit-serial 48/16 restoring
//   division and a hand-over; the item itself is taken first, in idle, and
//   its results then follow one after another.
// The shared one-bit-per-cycle divider takes most of the time of each result.
// Reset: asynchronous, active low; clears the state machine, previous speed,
//   output valid and the configuration registers (division_factor 0, step_size 80).
// Stalls: a result waits in the output register; the divider runs ahead on the
//   next speed and holds its quotient until that register frees up. After the
//   final result is loaded the next item is taken while it still waits.
module speed_ramp_reload_generator_core import srrg_pkg::*; #(
  parameter int unsigned MAX_RAMP_STEPS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  srrg_in_if.sink    in_i,
  srrg_out_if.source out_o,
  srrg_cfg_if.sink   cfg_i
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // Configuration is always taken and lands at once; write it only while idle.
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  srrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srrg_dp #(
    .MAX_RAMP_STEPS (MAX_RAMP_STEPS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .target_i     (in_i.target_speed),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_reload_o (out_o.reload_value),
    .out_speed_o  (out_o.ramp_speed),
    .out_last_o   (out_o.last)
  );

endmodule

// ----- design/srrg_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the speed ramp reload generator, bound to the top level.
// Depends on srrg_pkg.
module srrg_port_checker import srrg_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [RELOAD_W-1:0] reload_value_i,
  input logic [SPEED_W-1:0]  ramp_speed_i,
  input logic                last_i
);

  // an accepted item leaves the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken twice in a row");

  // while a ramp is still unfinished no new item may be taken
  a_no_accept_mid_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> !in_ready_i)
    else $error("input ready in the middle of a ramp");

  a_zero_speed_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (ramp_speed_i == '0) |-> (reload_value_i == '0))
    else $error("nonzero reload for zero speed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(reload_value_i)
      && $stable(ramp_speed_i) && $stable(last_i))
    else $error("stalled result changed");

endmodule

bind speed_ramp_reload_generator_core srrg_port_checker u_srrg_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .reload_value_i (out_o.reload_value),
  .ramp_speed_i   (out_o.ramp_speed),
  .last_i         (out_o.last)
);
